/* hdl/sbq_pkg.sv */
// Shared types, constants and saturation helpers for the stereo biquad filter.
`default_nettype none
package sbq_pkg;

   // Field and datapath widths
   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 32;
   localparam int DELAY_W   = 48;
   localparam int YR_W      = 32;
   localparam int PROD_W    = 64;
   localparam int PROD_SH   = 11;
   localparam int TERM_W    = PROD_W - PROD_SH;
   localparam int ACC_W     = 56;
   localparam int OUT_SH    = 17;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [DELAY_W-1:0] DELAY_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
   localparam logic signed [DELAY_W-1:0] DELAY_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [DELAY_W:0] ROUND_BIAS = (DELAY_W+1)'(1) << (OUT_SH - 1);

   // Coefficient reset values, Q3.28
   localparam logic signed [COEF_W-1:0] COEF_B0_RST = 32'sh1000_0000;
   localparam logic signed [COEF_W-1:0] COEF_ZERO_RST = '0;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A2 = 3'd4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } rsp_type;

   // Which product the multiplier forms this cycle
   typedef enum logic [2:0] {
      MUL_B0X,
      MUL_B1X,
      MUL_B2X,
      MUL_A1Y,
      MUL_A2Y
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MB0,
      ST_Y,
      ST_RND,
      ST_MA1,
      ST_S0,
      ST_S1,
      ST_OUT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic        capture;
      mul_sel_type mul_sel;
      logic        load_prod;
      logic        load_y;
      logic        load_rnd;
      logic        load_acc1;
      logic        write_s0;
      logic        write_s1;
      logic        load_out;
   } cmd_type;

   // Clamp a wide sum to a delay word
   function automatic logic signed [DELAY_W-1:0] sat_delay(input logic signed [ACC_W-1:0] v);
      logic signed [DELAY_W-1:0] r;
      if ((&v[ACC_W-1:DELAY_W-1]) || !(|v[ACC_W-1:DELAY_W-1])) begin
         r = v[DELAY_W-1:0];
      end else if (v[ACC_W-1]) begin
         r = DELAY_MIN;
      end else begin
         r = DELAY_MAX;
      end
      return r;
   endfunction

   // Clamp the rounded feedback value to an output sample
   function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [YR_W-1:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if ((&v[YR_W-1:SAMPLE_W-1]) || !(|v[YR_W-1:SAMPLE_W-1])) begin
         r = v[SAMPLE_W-1:0];
      end else if (v[YR_W-1]) begin
         r = OUT_MIN;
      end else begin
         r = OUT_MAX;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/sbq_lane.sv */
// One channel of the biquad datapath: multiplier, accumulators and delay words.
`default_nettype none
module sbq_lane (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire sbq_pkg::cmd_type                      cmd,
   input  wire logic signed [sbq_pkg::COEF_W-1:0]     coef,
   input  wire logic signed [sbq_pkg::SAMPLE_W-1:0]   x_in,
   output logic signed [sbq_pkg::SAMPLE_W-1:0]        out_sample
);
   import sbq_pkg::*;

   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [DELAY_W-1:0]  y_ff, y_in;
   logic signed [YR_W-1:0]     yr_ff, yr_in;
   logic signed [ACC_W-1:0]    acc0_ff, acc0_in;
   logic signed [ACC_W-1:0]    acc1_ff, acc1_in;
   logic signed [DELAY_W-1:0]  s0_ff, s0_in;
   logic signed [DELAY_W-1:0]  s1_ff, s1_in;
   logic signed [SAMPLE_W-1:0] out_ff;

   logic                       use_yr;
   logic signed [COEF_W-1:0]   operand;
   logic signed [TERM_W-1:0]   term;
   logic signed [ACC_W-1:0]    term_ext;
   logic signed [DELAY_W:0]    round_sum;

   // Pick the multiplier operand: input sample or rounded output
   assign use_yr  = (cmd.mul_sel == MUL_A1Y) || (cmd.mul_sel == MUL_A2Y);
   assign operand = use_yr ? yr_ff : COEF_W'(x_ff);
   assign prod_in = coef * operand;

   // Floor the product to 40 fractional bits
   assign term     = prod_ff[PROD_W-1:PROD_SH];
   assign term_ext = ACC_W'(term);

   // Full-precision output, then round half up to Q8.23
   assign y_in      = sat_delay(ACC_W'(s0_ff) + term_ext);
   assign round_sum = (DELAY_W+1)'(y_ff) + ROUND_BIAS;
   assign yr_in     = round_sum[DELAY_W:OUT_SH];

   // Next delay words
   assign acc0_in = ACC_W'(s1_ff) + term_ext;
   assign acc1_in = term_ext;
   assign s0_in   = sat_delay(acc0_ff - term_ext);
   assign s1_in   = sat_delay(acc1_ff - term_ext);

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= x_in;
      end
      if (cmd.load_prod) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_y) begin
         y_ff <= y_in;
      end
      if (cmd.load_rnd) begin
         yr_ff   <= yr_in;
         acc0_ff <= acc0_in;
      end
      if (cmd.load_acc1) begin
         acc1_ff <= acc1_in;
      end
      if (cmd.load_out) begin
         out_ff <= sat_out(yr_ff);
      end
   end

   // Filter state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff <= '0;
         s1_ff <= '0;
      end else begin
         if (cmd.write_s0) begin
            s0_ff <= s0_in;
         end
         if (cmd.write_s1) begin
            s1_ff <= s1_in;
         end
      end
   end

   assign out_sample = out_ff;

endmodule
`default_nettype wire

/* hdl/sbq_datapath.sv */
// Datapath: coefficient registers, coefficient select and the two channel lanes.
`default_nettype none
module sbq_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire sbq_pkg::cmd_type                  cmd,
   input  wire logic                              csr_wr_en,
   input  wire logic [sbq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sbq_pkg::COEF_W-1:0]        csr_wdata,
   input  wire sbq_pkg::req_type                  req_data,
   output sbq_pkg::rsp_type                       rsp_data
);
   import sbq_pkg::*;

   logic signed [COEF_W-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;
   logic signed [COEF_W-1:0] coef;

   // Write coefficients; ignore unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= COEF_B0_RST;
         coef_b1_ff <= COEF_ZERO_RST;
         coef_b2_ff <= COEF_ZERO_RST;
         coef_a1_ff <= COEF_ZERO_RST;
         coef_a2_ff <= COEF_ZERO_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COEF_B0: coef_b0_ff <= csr_wdata;
            CSR_COEF_B1: coef_b1_ff <= csr_wdata;
            CSR_COEF_B2: coef_b2_ff <= csr_wdata;
            CSR_COEF_A1: coef_a1_ff <= csr_wdata;
            CSR_COEF_A2: coef_a2_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Select the coefficient for this cycle's product
   always_comb begin
      case (cmd.mul_sel)
         MUL_B0X: coef = coef_b0_ff;
         MUL_B1X: coef = coef_b1_ff;
         MUL_B2X: coef = coef_b2_ff;
         MUL_A1Y: coef = coef_a1_ff;
         MUL_A2Y: coef = coef_a2_ff;
         default: coef = coef_b0_ff;
      endcase
   end

   sbq_lane u_left (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .coef       (coef),
      .x_in       (req_data.left_sample),
      .out_sample (rsp_data.left_out)
   );

   sbq_lane u_right (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .coef       (coef),
      .x_in       (req_data.right_sample),
      .out_sample (rsp_data.right_out)
   );

endmodule
`default_nettype wire

/* hdl/sbq_ctrl.sv */
// Controller: sequences the multiply-add steps and runs both handshakes.
`default_nettype none
module sbq_ctrl (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output sbq_pkg::cmd_type  cmd
);
   import sbq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Output register can take a word when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      cmd.capture   = 1'b0;
      cmd.mul_sel   = MUL_B0X;
      cmd.load_prod = 1'b0;
      cmd.load_y    = 1'b0;
      cmd.load_rnd  = 1'b0;
      cmd.load_acc1 = 1'b0;
      cmd.write_s0  = 1'b0;
      cmd.write_s1  = 1'b0;
      cmd.load_out  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MB0;
            end
         end
         ST_MB0: begin
            cmd.mul_sel   = MUL_B0X;
            cmd.load_prod = 1'b1;
            state_in      = ST_Y;
         end
         ST_Y: begin
            cmd.load_y    = 1'b1;
            cmd.mul_sel   = MUL_B1X;
            cmd.load_prod = 1'b1;
            state_in      = ST_RND;
         end
         ST_RND: begin
            cmd.load_rnd  = 1'b1;
            cmd.mul_sel   = MUL_B2X;
            cmd.load_prod = 1'b1;
            state_in      = ST_MA1;
         end
         ST_MA1: begin
            cmd.load_acc1 = 1'b1;
            cmd.mul_sel   = MUL_A1Y;
            cmd.load_prod = 1'b1;
            state_in      = ST_S0;
         end
         ST_S0: begin
            cmd.write_s0  = 1'b1;
            cmd.mul_sel   = MUL_A2Y;
            cmd.load_prod = 1'b1;
            state_in      = ST_S1;
         end
         ST_S1: begin
            cmd.write_s1 = 1'b1;
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result word until taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* hdl/stereo_biquad_filter.sv */
// Top level of the stereo biquad filter: controller plus datapath.
//
// One transposed direct form II biquad applied to a left and a right Q1.23 sample per word,
// with five shared Q3.28 coefficients written through the csr_ port (index 0 to 4: b0, b1,
// b2, a1, a2; other indexes are ignored). Each channel keeps two saturating 48-bit delay
// words, cleared by reset. A word is accepted in idle and runs six steps: in five, one 32x32
// multiplier per channel forms the five products in turn, with the output rounding
// between the feedforward and feedback products; a last step writes the second delay word
// and, once the output register is free, the output. The controller returns to idle when
// the output is loaded, so a word is accepted only after the last one is through. Results
// sit in an output register, so the next word is taken while a result waits. Coefficients
// must be written only while the filter is idle; the block itself does not enforce this.
`default_nettype none
module stereo_biquad_filter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire sbq_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output sbq_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_wr_en,
   input  wire logic [sbq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [sbq_pkg::COEF_W-1:0]        csr_wdata
);
   import sbq_pkg::*;

   cmd_type cmd;

   sbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   sbq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
